// ===== hw/rtl/hcml_pkg.sv =====
// ----------------------------------------------------------------------------
// hcml_pkg
// Shared types, codes and character helpers of the hex command memory loader.
// ----------------------------------------------------------------------------
package hcml_pkg;

	localparam int ADDR_WIDTH_DEF  = 32;
	localparam int COUNT_WIDTH_DEF = 32;
	localparam int QUEUE_DEPTH     = 4;

	// parser phases
	localparam logic [2:0] PH_MAGIC = 3'd0;
	localparam logic [2:0] PH_CMD   = 3'd1;
	localparam logic [2:0] PH_ADDR  = 3'd2;
	localparam logic [2:0] PH_SIZE  = 3'd3;
	localparam logic [2:0] PH_DHDR  = 3'd4;
	localparam logic [2:0] PH_DATA  = 3'd5;

	// event kinds
	localparam logic [1:0] EV_WRITE  = 2'd0;
	localparam logic [1:0] EV_ERROR  = 2'd1;
	localparam logic [1:0] EV_NODATA = 2'd2;

	// mode codes
	localparam logic [1:0] MODE_NONE = 2'd0;
	localparam logic [1:0] MODE_ONE  = 2'd1;
	localparam logic [1:0] MODE_TWO  = 2'd2;
	localparam logic [1:0] MODE_THR  = 2'd3;

	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_C     = 8'h63;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UD    = 8'h44;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_UR    = 8'h52;
	localparam logic [7:0] CH_UT    = 8'h54;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_S     = 8'h73;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_TWO   = 8'h32;
	localparam logic [7:0] CH_FOUR  = 8'h34;
	localparam logic [7:0] CH_EIGHT = 8'h38;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] HEX_TEN  = 8'd10;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic       last;
	} hcml_evt_t;

	// bit 4 set: not a hex digit
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [7:0] v;
		v = 8'd0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			v = c - CH_ZERO;
			return {1'b0, v[3:0]};
		end
		if (c >= CH_A && c <= CH_F) begin
			v = c - CH_A + HEX_TEN;
			return {1'b0, v[3:0]};
		end
		if (c >= CH_UA && c <= CH_UF) begin
			v = c - CH_UA + HEX_TEN;
			return {1'b0, v[3:0]};
		end
		return 5'h10;
	endfunction

	function automatic logic [7:0] magic_char(input logic [1:0] pos);
		logic [7:0] r;
		unique case (pos)
			2'd0: r = CH_A;
			2'd1: r = CH_B;
			2'd2: r = CH_C;
			default: r = CH_D;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] lit_char(input logic is_addr, input logic [1:0] pos);
		logic [7:0] r;
		unique case (pos)
			2'd0: r = CH_DOT;
			2'd1: r = is_addr ? CH_A : CH_S;
			2'd2: r = CH_ZERO;
			default: r = CH_X;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] addr_digits(input logic [1:0] mode);
		logic [4:0] r;
		unique case (mode)
			MODE_ONE: r = 5'd8;
			MODE_TWO: r = 5'd16;
			default:  r = 5'd0;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] size_digits(input logic [1:0] mode);
		logic [4:0] r;
		unique case (mode)
			MODE_ONE: r = 5'd4;
			MODE_TWO: r = 5'd8;
			MODE_THR: r = 5'd16;
			default:  r = 5'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== hw/rtl/hcml_front.sv =====
// ----------------------------------------------------------------------------
// hcml_front
// Command parser: consumes one character per beat, tracks phase, modes,
// address, size and byte index, and issues write/error/no-data events.
// ----------------------------------------------------------------------------
module hcml_front #(
	parameter int ADDR_WIDTH  = hcml_pkg::ADDR_WIDTH_DEF,
	parameter int COUNT_WIDTH = hcml_pkg::COUNT_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  logic [7:0]             rx_char,
	output logic                   push,
	output hcml_pkg::hcml_evt_t    push_evt,
	output logic [ADDR_WIDTH-1:0]  push_base,
	output logic [COUNT_WIDTH-1:0] push_index
);

	logic [2:0]             phase_q, phase_d;
	logic [4:0]             pos_q, pos_d, pos_n;
	logic [1:0]             comm_q, comm_d;
	logic [1:0]             amode_q, amode_d;
	logic [1:0]             smode_q, smode_d;
	logic [ADDR_WIDTH-1:0]  base_q, base_d;
	logic [COUNT_WIDTH-1:0] total_q, total_d;
	logic [COUNT_WIDTH-1:0] index_q, index_d;
	logic [3:0]             hi_q, hi_d;
	logic                   nib_q, nib_d;
	logic [4:0]             hv;
	logic [3:0]             hd;
	logic [4:0]             cnt;
	logic                   is_addr;
	logic                   fail;
	logic                   last;

	always_comb begin
		phase_d    = phase_q;
		pos_d      = pos_q;
		comm_d     = comm_q;
		amode_d    = amode_q;
		smode_d    = smode_q;
		base_d     = base_q;
		total_d    = total_q;
		index_d    = index_q;
		hi_d       = hi_q;
		nib_d      = nib_q;
		push       = 1'b0;
		push_evt   = '{kind: hcml_pkg::EV_WRITE, data: 8'd0, last: 1'b0};
		push_base  = '0;
		push_index = '0;
		fail       = 1'b0;
		hv         = hcml_pkg::hex_value(rx_char);
		hd         = hv[4] ? 4'h0 : hv[3:0];
		pos_n      = pos_q + 5'd1;
		is_addr    = (phase_q == hcml_pkg::PH_ADDR);
		cnt        = is_addr ? hcml_pkg::addr_digits(amode_q) : hcml_pkg::size_digits(smode_q);
		last       = (total_q == '0) || (index_q >= total_q - COUNT_WIDTH'(1));
		if (accept) begin
			unique case (phase_q)
				hcml_pkg::PH_CMD: begin
					pos_d = pos_n;
					unique case (pos_q)
						5'd0: begin
							if (rx_char != hcml_pkg::CH_DOT)
								fail = 1'b1;
						end
						5'd1: begin
							if (rx_char == hcml_pkg::CH_T || rx_char == hcml_pkg::CH_UT)
								comm_d = hcml_pkg::MODE_TWO;
							else if (rx_char == hcml_pkg::CH_R || rx_char == hcml_pkg::CH_UR)
								comm_d = hcml_pkg::MODE_ONE;
							else if (rx_char == hcml_pkg::CH_D || rx_char == hcml_pkg::CH_UD)
								comm_d = hcml_pkg::MODE_THR;
						end
						5'd2: begin
							if (rx_char == hcml_pkg::CH_FOUR)
								amode_d = hcml_pkg::MODE_ONE;
							else if (rx_char == hcml_pkg::CH_EIGHT)
								amode_d = hcml_pkg::MODE_TWO;
						end
						5'd3: begin
							if (rx_char != hcml_pkg::CH_X)
								fail = 1'b1;
						end
						default: begin
							if (rx_char == hcml_pkg::CH_TWO)
								smode_d = hcml_pkg::MODE_ONE;
							else if (rx_char == hcml_pkg::CH_FOUR)
								smode_d = hcml_pkg::MODE_TWO;
							else if (rx_char == hcml_pkg::CH_EIGHT)
								smode_d = hcml_pkg::MODE_THR;
							phase_d = hcml_pkg::PH_ADDR;
							pos_d   = 5'd0;
						end
					endcase
				end
				hcml_pkg::PH_ADDR, hcml_pkg::PH_SIZE: begin
					if (pos_q < 5'd4) begin
						if (rx_char != hcml_pkg::lit_char(is_addr, pos_q[1:0]))
							fail = 1'b1;
					end else if (!hv[4]) begin
						if (is_addr)
							base_d = {base_q[ADDR_WIDTH-5:0], hv[3:0]};
						else
							total_d = {total_q[COUNT_WIDTH-5:0], hv[3:0]};
					end
					pos_d = pos_n;
					if (pos_n >= 5'd4 && (pos_n - 5'd4) >= cnt) begin
						phase_d = is_addr ? hcml_pkg::PH_SIZE : hcml_pkg::PH_DHDR;
						pos_d   = 5'd0;
					end
				end
				hcml_pkg::PH_DHDR: begin
					if (pos_q == 5'd0) begin
						if (rx_char != hcml_pkg::CH_DOT)
							fail = 1'b1;
						else
							pos_d = 5'd1;
					end else if (rx_char != hcml_pkg::CH_D) begin
						fail = 1'b1;
					end else begin
						pos_d = 5'd0;
						if (comm_q == hcml_pkg::MODE_TWO) begin
							phase_d = hcml_pkg::PH_DATA;
							index_d = '0;
							nib_d   = 1'b0;
							hi_d    = 4'h0;
						end else begin
							phase_d       = hcml_pkg::PH_MAGIC;
							push          = 1'b1;
							push_evt.kind = hcml_pkg::EV_NODATA;
						end
					end
				end
				hcml_pkg::PH_DATA: begin
					if (!nib_q) begin
						hi_d  = hd;
						nib_d = 1'b1;
					end else begin
						nib_d      = 1'b0;
						push       = 1'b1;
						push_evt   = '{kind: hcml_pkg::EV_WRITE, data: {hi_q, hd}, last: last};
						push_base  = base_q;
						push_index = index_q;
						if (last) begin
							phase_d = hcml_pkg::PH_MAGIC;
							pos_d   = 5'd0;
						end else begin
							index_d = index_q + COUNT_WIDTH'(1);
						end
					end
				end
				default: begin
					if (rx_char != hcml_pkg::magic_char(pos_q[1:0])) begin
						fail = 1'b1;
					end else if (pos_q[1:0] == 2'd3) begin
						phase_d = hcml_pkg::PH_CMD;
						pos_d   = 5'd0;
					end else begin
						phase_d = hcml_pkg::PH_MAGIC;
						pos_d   = {3'd0, pos_q[1:0]} + 5'd1;
					end
				end
			endcase
			if (fail) begin
				phase_d       = hcml_pkg::PH_MAGIC;
				pos_d         = 5'd0;
				push          = 1'b1;
				push_evt      = '{kind: hcml_pkg::EV_ERROR, data: 8'd0, last: 1'b0};
				push_base     = '0;
				push_index    = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hcml_pkg::PH_MAGIC;
			pos_q   <= 5'd0;
			comm_q  <= hcml_pkg::MODE_NONE;
			amode_q <= hcml_pkg::MODE_NONE;
			smode_q <= hcml_pkg::MODE_NONE;
			base_q  <= '0;
			total_q <= '0;
			index_q <= '0;
			hi_q    <= 4'h0;
			nib_q   <= 1'b0;
		end else begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			comm_q  <= comm_d;
			amode_q <= amode_d;
			smode_q <= smode_d;
			base_q  <= base_d;
			total_q <= total_d;
			index_q <= index_d;
			hi_q    <= hi_d;
			nib_q   <= nib_d;
		end
	end

endmodule

// ===== hw/rtl/hcml_queue.sv =====
// ----------------------------------------------------------------------------
// hcml_queue
// Small FIFO of parsed events between parser and output stage.
// ----------------------------------------------------------------------------
module hcml_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = hcml_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	output logic             head_valid,
	input  logic             pop,
	output logic [WIDTH-1:0] head_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

// ===== hw/rtl/hcml_back.sv =====
// ----------------------------------------------------------------------------
// hcml_back
// Output stage: forms the write address and holds the result beat until
// the downstream side takes it.
// ----------------------------------------------------------------------------
module hcml_back #(
	parameter int ADDR_WIDTH  = hcml_pkg::ADDR_WIDTH_DEF,
	parameter int COUNT_WIDTH = hcml_pkg::COUNT_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   head_valid,
	output logic                   pop,
	input  hcml_pkg::hcml_evt_t    head_evt,
	input  logic [ADDR_WIDTH-1:0]  head_base,
	input  logic [COUNT_WIDTH-1:0] head_index,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [39:0]            m_axis_tdata,  // write_address[31:0], write_data[39:32]
	output logic [1:0]             m_axis_tuser,  // event_res
	output logic                   m_axis_tlast
);

	localparam int OUT_W = (ADDR_WIDTH > 32) ? ADDR_WIDTH : 32;

	logic [ADDR_WIDTH-1:0] sum;
	logic [OUT_W-1:0]      sum_ext;
	logic                  valid_q;
	logic [31:0]           addr_q;
	logic [7:0]            data_q;
	logic [1:0]            kind_q;
	logic                  last_q;

	assign sum     = head_base + ADDR_WIDTH'(head_index);
	assign sum_ext = OUT_W'(sum);
	assign pop     = head_valid && (!valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || m_axis_tready) begin
			valid_q <= head_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			addr_q <= sum_ext[31:0];
			data_q <= head_evt.data;
			kind_q <= head_evt.kind;
			last_q <= head_evt.last;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {data_q, addr_q};
	assign m_axis_tuser  = kind_q;
	assign m_axis_tlast  = last_q;

endmodule

// ===== hw/rtl/hex_command_memory_loader_top.sv =====
// ----------------------------------------------------------------------------
// hex_command_memory_loader_top
// Parses hex command text and turns its data part into byte write beats.
// ----------------------------------------------------------------------------
// One character is taken per clock. The parser updates its state in the
// cycle of the beat and posts any write, error or no-data event into a
// four-entry queue; the output stage adds base address and byte index and
// presents the result from its own output register, which holds it until taken. Input is held
// off only while the queue is full, which happens only under output stall.
module hex_command_memory_loader_top #(
	parameter int ADDR_WIDTH  = hcml_pkg::ADDR_WIDTH_DEF,
	parameter int COUNT_WIDTH = hcml_pkg::COUNT_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // rx_char
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // write_address[31:0], write_data[39:32]
	output logic [1:0]  m_axis_tuser,   // event_res
	output logic        m_axis_tlast    // last_byte
);

	localparam int EVT_W = $bits(hcml_pkg::hcml_evt_t);
	localparam int Q_W   = EVT_W + ADDR_WIDTH + COUNT_WIDTH;

	logic                   accept;
	logic                   push;
	hcml_pkg::hcml_evt_t    push_evt;
	logic [ADDR_WIDTH-1:0]  push_base;
	logic [COUNT_WIDTH-1:0] push_index;
	logic                   q_full;
	logic                   head_valid;
	logic                   pop;
	logic [Q_W-1:0]         head_data;
	hcml_pkg::hcml_evt_t    head_evt;
	logic [ADDR_WIDTH-1:0]  head_base;
	logic [COUNT_WIDTH-1:0] head_index;

	assign s_axis_tready = !q_full;
	assign accept        = s_axis_tvalid && s_axis_tready;

	hcml_front #(
		.ADDR_WIDTH  (ADDR_WIDTH),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.rx_char    (s_axis_tdata),
		.push       (push),
		.push_evt   (push_evt),
		.push_base  (push_base),
		.push_index (push_index)
	);

	hcml_queue #(
		.WIDTH (Q_W),
		.DEPTH (hcml_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  ({push_base, push_index, push_evt}),
		.full       (q_full),
		.head_valid (head_valid),
		.pop        (pop),
		.head_data  (head_data)
	);

	assign head_evt   = head_data[EVT_W-1:0];
	assign head_index = head_data[EVT_W +: COUNT_WIDTH];
	assign head_base  = head_data[EVT_W + COUNT_WIDTH +: ADDR_WIDTH];

	hcml_back #(
		.ADDR_WIDTH  (ADDR_WIDTH),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.pop           (pop),
		.head_evt      (head_evt),
		.head_base     (head_base),
		.head_index    (head_index),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser == hcml_pkg::EV_WRITE ||
			m_axis_tuser == hcml_pkg::EV_ERROR || m_axis_tuser == hcml_pkg::EV_NODATA))
		else $error("undefined event kind on output");

	a_last_is_write: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == hcml_pkg::EV_WRITE))
		else $error("last marker on a non-write beat");

	a_event_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser != hcml_pkg::EV_WRITE) |->
			(m_axis_tdata == 40'd0 && !m_axis_tlast))
		else $error("error or no-data beat with nonzero payload");

	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && $past(m_axis_tvalid && !m_axis_tready)))
		else $error("input held off without output backpressure");

endmodule
